### rtl/core/word_frequency_subsampler_assert.svh
// assertion macros used by the subsampler top level
`ifndef WORD_FREQUENCY_SUBSAMPLER_ASSERT_SVH
`define WORD_FREQUENCY_SUBSAMPLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/wfs_pkg.sv
// shared constants, types and state codes of the word frequency subsampler
package wfs_pkg;

  // default sizes
  localparam int VOCAB_SIZE_DEF = 65536;
  localparam int FREQ_WIDTH_DEF = 32;

  // field and register widths
  localparam int IDX_W   = 16;
  localparam int RND_W   = 30;
  localparam int THR_W   = 32;
  localparam int TOTAL_W = 40;
  localparam int TL_W    = 16;
  localparam int TH_W    = TOTAL_W - TL_W;
  localparam int Q_W     = THR_W + TH_W;
  localparam int R_W     = 32;
  localparam int SQ_W    = 32;
  localparam int S_W     = 16;
  localparam int RND_SHIFT = RND_W - S_W;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd42950;
  // ceil(0.38254554 * 2^16)
  localparam logic [R_W-1:0]   KEEP_RATIO_Q    = 32'd25071;

  typedef enum logic {
    OP_COUNT  = 1'b0,
    OP_DECIDE = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_WR,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SQRT_WAIT,
    ST_DONE
  } state_t;

  // status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### rtl/core/word_frequency_subsampler.sv
// top level: frequency counting and keep-or-drop subsampling decisions
//
//  channel | direction | ports                                       | handshake
//  --------+-----------+---------------------------------------------+------------------
//  in      | request   | in_op, in_word_index, in_random_value       | in_valid/in_stall
//  out     | result    | out_kept_word_index                         | out_valid/out_stall
//  cfg     | write     | cfg_wdata (sample threshold)                | cfg_we
//
// count request: frequency store read, then saturating write back.
// decide request: keeps the word when the frequency is zero; else the divider runs, and
//   a saturated ratio or one that reaches the keep level keeps the word; else the square
//   root runs and the random draw decides; the 32-step divider and 16-step root iterate.
// after reset a clearing pass writes zero to all VOCAB_SIZE entries, one per cycle,
//   while in_stall stays high; threshold writes are taken during it.
// a waiting result does not block new requests; only a kept word that finds the
//   output register still stalled holds the block until out_stall drops.
`include "word_frequency_subsampler_assert.svh"

module word_frequency_subsampler #(
  parameter int VOCAB_SIZE = wfs_pkg::VOCAB_SIZE_DEF,
  parameter int FREQ_WIDTH = wfs_pkg::FREQ_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [wfs_pkg::IDX_W-1:0]   in_word_index,
  input  logic [wfs_pkg::RND_W-1:0]   in_random_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wfs_pkg::IDX_W-1:0]   out_kept_word_index,
  input  logic                        cfg_we,
  input  logic [wfs_pkg::THR_W-1:0]   cfg_wdata
);
  import wfs_pkg::*;

  localparam int ADDR_W  = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
  localparam int EXT_W   = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam int RANGE_W = EXT_W + 1;

  state_t                state_r, state_nxt;
  logic                  keep_r, keep_nxt;
  logic [ADDR_W-1:0]     clr_cnt_r;
  logic [THR_W-1:0]      thr_r;
  logic [TOTAL_W-1:0]    total_r;
  logic                  out_valid_r;
  logic [IDX_W-1:0]      out_idx_r;

  logic [IDX_W-1:0]      idx_r;
  logic [ADDR_W-1:0]     addr_r;
  logic                  in_range_r;
  logic [RND_W-1:0]      rnd_r;
  logic [FREQ_WIDTH-1:0] freq_r;
  logic [Q_W-1:0]        q_r;
  logic [Q_W-1:0]        ph_r;

  logic [EXT_W-1:0]      idx_ext;
  logic [ADDR_W-1:0]     in_addr;
  logic                  in_range;
  logic                  in_stall_c;
  logic                  out_load;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  logic [FREQ_WIDTH-1:0] mem_wd;
  logic [FREQ_WIDTH-1:0] mem_rd;
  logic [FREQ_WIDTH-1:0] freq_inc;

  logic [TH_W-1:0]       mul_b;
  logic [Q_W-1:0]        prod;

  logic                  div_start;
  unit_stat_t            div_stat;
  logic [R_W-1:0]        div_q;
  logic                  sqrt_start;
  unit_stat_t            sqrt_stat;
  logic [S_W-1:0]        sqrt_s;
  logic [S_W:0]          sr_sum;
  logic [RND_W:0]        rnd_bound;

  // index decode and range check
  assign idx_ext  = EXT_W'(in_word_index);
  assign in_addr  = idx_ext[ADDR_W-1:0];
  assign in_range = {1'b0, idx_ext} < RANGE_W'(VOCAB_SIZE);

  // saturating frequency increment
  assign freq_inc = (mem_rd == '1) ? mem_rd : mem_rd + 1'b1;

  // shared multiplier: low then high half of the corpus total
  assign mul_b = (state_r == ST_MUL_LO) ? TH_W'(total_r[TL_W-1:0]) : total_r[TOTAL_W-1:TL_W];
  assign prod  = thr_r * mul_b;

  // keep bound (s + r) * 2^14 for the random draw
  assign sr_sum    = (S_W+1)'(sqrt_s) + (S_W+1)'(div_q[S_W-1:0]);
  assign rnd_bound = {sr_sum, {RND_SHIFT{1'b0}}};

  // next state and control
  always_comb begin
    state_nxt  = state_r;
    keep_nxt   = keep_r;
    in_stall_c = 1'b1;
    mem_we     = 1'b0;
    mem_wa     = addr_r;
    mem_wd     = freq_inc;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
        if (clr_cnt_r == ADDR_W'(VOCAB_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_c = 1'b0;
        keep_nxt   = 1'b0;
        if (in_valid) begin
          state_nxt = (in_op == OP_DECIDE) ? ST_MUL_LO : ST_CNT_WR;
        end
      end
      ST_CNT_WR: begin
        mem_we    = in_range_r;
        state_nxt = ST_IDLE;
      end
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_DIV_GO;
      ST_DIV_GO: begin
        if (freq_r == '0) begin
          keep_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          if (div_q >= KEEP_RATIO_Q) begin
            keep_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            sqrt_start = 1'b1;
            state_nxt  = ST_SQRT_WAIT;
          end
        end
      end
      ST_SQRT_WAIT: begin
        if (sqrt_stat.done) begin
          keep_nxt  = (RND_W+1)'(rnd_r) < rnd_bound;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!keep_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      keep_r      <= 1'b0;
      clr_cnt_r   <= '0;
      thr_r       <= THRESHOLD_RESET;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      keep_r  <= keep_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (state_r == ST_CNT_WR && in_range_r && total_r != '1) begin
        total_r <= total_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      idx_r      <= in_word_index;
      addr_r     <= in_addr;
      in_range_r <= in_range;
      rnd_r      <= in_random_value;
    end
    if (state_r == ST_MUL_LO) begin
      freq_r <= in_range_r ? mem_rd : '0;
      q_r    <= {{TL_W{1'b0}}, prod[Q_W-1:TL_W]};
    end
    if (state_r == ST_MUL_HI) begin
      ph_r <= prod;
    end
    if (state_r == ST_SUM) begin
      q_r <= q_r + ph_r;
    end
    if (out_load) begin
      out_idx_r <= idx_r;
    end
  end

  // frequency store
  wfs_freq_mem #(
    .DEPTH  (VOCAB_SIZE),
    .ADDR_W (ADDR_W),
    .DATA_W (FREQ_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_addr (in_addr),
    .rd_data (mem_rd),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd)
  );

  // ratio divider
  wfs_div #(
    .FREQ_WIDTH (FREQ_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_r),
    .divisor  (freq_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // square root of the ratio in q16.16
  wfs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({div_q[S_W-1:0], {S_W{1'b0}}}),
    .stat     (sqrt_stat),
    .root     (sqrt_s)
  );

  assign in_stall            = in_stall_c;
  assign out_valid           = out_valid_r;
  assign out_kept_word_index = out_idx_r;

  // checks
  `WFS_ASSERT_IMP(a_units_idle, state_r == ST_IDLE, !div_stat.busy && !sqrt_stat.busy, "arithmetic unit busy while idle")
  `WFS_ASSERT_IMP(a_div_done_wait, div_stat.done, state_r == ST_DIV_WAIT, "divider result outside wait state")
  `WFS_ASSERT_IMP(a_mem_write_state, mem_we, state_r == ST_CLEAR || state_r == ST_CNT_WR, "frequency store written outside count or clear")
  `WFS_ASSERT_NXT(a_total_mono, state_r != ST_CLEAR, total_r >= $past(total_r), "corpus total decreased")

endmodule

### rtl/core/wfs_freq_mem.sv
// word frequency store: one write port, one registered read port
module wfs_freq_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write and registered read, read returns old data on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/wfs_div.sv
// restoring divider: 32-bit saturating quotient of the scaled product by the frequency
module wfs_div #(
  parameter int FREQ_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wfs_pkg::Q_W-1:0]     dividend,
  input  logic [FREQ_WIDTH-1:0]       divisor,
  output wfs_pkg::unit_stat_t         stat,
  output logic [wfs_pkg::R_W-1:0]     quotient
);
  import wfs_pkg::*;

  localparam int HI_W  = Q_W - R_W;
  localparam int CMP_W = (HI_W > FREQ_WIDTH) ? HI_W : FREQ_WIDTH;
  localparam int CNT_W = $clog2(R_W);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [FREQ_WIDTH-1:0] den_r;
  logic [FREQ_WIDTH-1:0] rem_r;
  logic [R_W-1:0]        low_r;
  logic [R_W-1:0]        quo_r;

  logic [HI_W-1:0]       hi;
  logic                  sat;
  logic [FREQ_WIDTH:0]   rem_sh;
  logic [FREQ_WIDTH:0]   diff;
  logic                  ge;

  // quotient overflows 32 bits when the upper part already reaches the divisor
  assign hi     = dividend[Q_W-1:R_W];
  assign sat    = CMP_W'(hi) >= CMP_W'(divisor);
  assign rem_sh = {rem_r, low_r[R_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = rem_sh >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !sat;
        done_r <= sat;
        cnt_r  <= CNT_W'(R_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= divisor;
      rem_r <= FREQ_WIDTH'(hi);
      low_r <= dividend[R_W-1:0];
      if (sat) begin
        quo_r <= '1;
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff[FREQ_WIDTH-1:0] : rem_sh[FREQ_WIDTH-1:0];
      low_r <= {low_r[R_W-2:0], 1'b0};
      quo_r <= {quo_r[R_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

### rtl/core/wfs_sqrt.sv
// bit-pair integer square root, one result bit per cycle
module wfs_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [wfs_pkg::SQ_W-1:0] radicand,
  output wfs_pkg::unit_stat_t      stat,
  output logic [wfs_pkg::S_W-1:0]  root
);
  import wfs_pkg::*;

  logic            busy_r;
  logic            done_r;
  logic [SQ_W-1:0] v_r;
  logic [SQ_W-1:0] res_r;
  logic [SQ_W-1:0] bit_r;
  logic [SQ_W-1:0] trial;

  assign trial = res_r + bit_r;

  // control, the one-hot bit marks the last step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // trial subtract per bit pair
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res_r <= '0;
      bit_r <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = res_r[S_W-1:0];

endmodule
